### src/pgw_pkg.sv
package pgw_pkg;

  // default parameter values
  localparam int VA_BITS_DEF = 38;
  localparam int PA_BITS_DEF = 34;

  // fixed field widths
  localparam int ADDR_W     = 35;
  localparam int DIR_BASE_W = 34;
  localparam int ENTRY_W    = 32;
  localparam int ACT_W      = 2;
  localparam int ACC_W      = 2;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;

  // page geometry
  localparam int DIR_SHIFT_128K      = 27;
  localparam int DIR_SHIFT_64K       = 26;
  localparam int PAGE_SHIFT_BIG_128K = 17;
  localparam int PAGE_SHIFT_BIG_64K  = 16;
  localparam int PAGE_SHIFT_SMALL    = 12;
  localparam int BIG_RANGE_BIT       = 34;
  localparam int ENTRY_FRAME_LSB     = 4;
  localparam int FRAME_SHIFT         = 12;
  localparam int ENTRY_SIZE_SHIFT    = 3;
  localparam int PSHIFT_W            = 5;

  // entry bit positions
  localparam int LO_VALID_BIT     = 0;
  localparam int LO_READ_ONLY_BIT = 2;
  localparam int HI_BIG_AP_BIT    = 3;
  localparam int HI_SMALL_AP_BIT  = 0;
  localparam int HI_SMALL_VLD_BIT = 2;
  localparam int HI_RD_DIS_BIT    = 30;
  localparam int ACC_READ_BIT     = 0;
  localparam int ACC_WRITE_BIT    = 1;

  // action codes
  localparam logic [ACT_W-1:0] ACT_START       = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DIR_REPLY   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TABLE_REPLY = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_FETCH_DIR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FETCH_TABLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE        = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DECODE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ACCESS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BUS    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIR_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_PAGE = 1'd1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIR,
    PH_TABLE
  } phase_t;

  typedef struct packed {
    logic [DIR_BASE_W-1:0] dir_base;
    logic                  big_page_128k;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [KIND_W-1:0]   result_kind;
    logic [ADDR_W-1:0]   address;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

### src/pgw_if.sv
interface pgw_in_if import pgw_pkg::*; #(
  parameter int VA_W = VA_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [VA_W-1:0]    virt_addr;
  logic [ACC_W-1:0]   access_kind;
  logic [ENTRY_W-1:0] entry_lo;
  logic [ENTRY_W-1:0] entry_hi;
  logic               bus_error;

  modport source (output valid, action, virt_addr, access_kind, entry_lo, entry_hi,
                  bus_error, input ready);
  modport sink (input valid, action, virt_addr, access_kind, entry_lo, entry_hi,
                bus_error, output ready);
endinterface

interface pgw_out_if import pgw_pkg::*;;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   result_kind;
  logic [ADDR_W-1:0]   address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, result_kind, address, status, input ready);
  modport sink (input valid, result_kind, address, status, output ready);
endinterface

### src/pgw_cfg_regs.sv
module pgw_cfg_regs import pgw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIR_BASE_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DIR_BASE: cfg_nxt.dir_base = cfg_wdata;
        REG_BIG_PAGE: cfg_nxt.big_page_128k = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dir_base      <= '0;
      cfg_r.big_page_128k <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/pgw_step.sv
module pgw_step import pgw_pkg::*; #(
  parameter int VA_W = VA_BITS_DEF,
  parameter int PA_W = PA_BITS_DEF
) (
  input  cfg_t               cfg,
  input  phase_t             phase,
  input  logic [VA_W-1:0]    pend_va,
  input  logic [ACC_W-1:0]   pend_acc,
  input  logic [ACT_W-1:0]   action,
  input  logic [VA_W-1:0]    item_va,
  input  logic [ENTRY_W-1:0] entry_lo,
  input  logic [ENTRY_W-1:0] entry_hi,
  input  logic               bus_error,
  output result_t            res,
  output phase_t             phase_nxt
);

  localparam int VX_W    = (VA_W > ADDR_W) ? VA_W : ADDR_W;
  localparam int FRAME_W = ENTRY_W - ENTRY_FRAME_LSB + FRAME_SHIFT;
  localparam int SPAN_W  = DIR_SHIFT_128K;
  localparam int OFS_W   = PAGE_SHIFT_BIG_128K;
  localparam logic [63:0] PA_MASK = (64'd1 << PA_W) - 64'd1;
  localparam logic [SPAN_W-1:0] SPAN_MASK_64K = SPAN_W'((64'd1 << DIR_SHIFT_64K) - 64'd1);

  logic [VX_W-1:0]     va_x;
  logic                big_range;
  logic [VX_W-1:0]     dir_idx;
  logic [ADDR_W-1:0]   root_base;
  logic [ADDR_W-1:0]   dir_fetch_addr;
  logic [SPAN_W-1:0]   span;
  logic [PSHIFT_W-1:0] pshift;
  logic [SPAN_W-1:0]   tbl_idx;
  logic                big_ap;
  logic                small_ap;
  logic [ENTRY_W-1:0]  frame_src;
  logic [FRAME_W-1:0]  dir_frame;
  logic [ADDR_W-1:0]   tbl_fetch_addr;
  logic [FRAME_W-1:0]  page_frame;
  logic [OFS_W-1:0]    ofs_mask;
  logic [ADDR_W-1:0]   phys_addr;
  logic                access_fault;

  // address arithmetic for all three phases
  always_comb begin
    va_x      = (action == ACT_START) ? VX_W'(item_va) : VX_W'(pend_va);
    big_range = |va_x[VX_W-1:BIG_RANGE_BIT];

    // directory entry address
    dir_idx = cfg.big_page_128k ? (va_x >> DIR_SHIFT_128K) : (va_x >> DIR_SHIFT_64K);
    root_base = ADDR_W'(cfg.dir_base & PA_MASK[DIR_BASE_W-1:0]);
    dir_fetch_addr = root_base + ADDR_W'(dir_idx << ENTRY_SIZE_SHIFT);

    // page size for this address
    if (!big_range) begin
      pshift = PSHIFT_W'(PAGE_SHIFT_SMALL);
    end else if (cfg.big_page_128k) begin
      pshift = PSHIFT_W'(PAGE_SHIFT_BIG_128K);
    end else begin
      pshift = PSHIFT_W'(PAGE_SHIFT_BIG_64K);
    end

    // table entry address
    span = va_x[SPAN_W-1:0];
    if (!cfg.big_page_128k) begin
      span = span & SPAN_MASK_64K;
    end
    tbl_idx   = span >> pshift;
    big_ap    = entry_lo[LO_VALID_BIT] && entry_hi[HI_BIG_AP_BIT];
    small_ap  = entry_hi[HI_SMALL_AP_BIT] && entry_hi[HI_SMALL_VLD_BIT];
    frame_src = big_ap ? entry_lo : entry_hi;
    dir_frame = {frame_src[ENTRY_W-1:ENTRY_FRAME_LSB], {FRAME_SHIFT{1'b0}}}
                & PA_MASK[FRAME_W-1:0];
    tbl_fetch_addr = dir_frame[ADDR_W-1:0] + (ADDR_W'(tbl_idx) << ENTRY_SIZE_SHIFT);

    // physical address
    page_frame = {entry_lo[ENTRY_W-1:ENTRY_FRAME_LSB], {FRAME_SHIFT{1'b0}}}
                 & PA_MASK[FRAME_W-1:0];
    ofs_mask  = ~({OFS_W{1'b1}} << pshift);
    phys_addr = page_frame[ADDR_W-1:0] | ADDR_W'(va_x[OFS_W-1:0] & ofs_mask);

    access_fault = (entry_lo[LO_READ_ONLY_BIT] && pend_acc[ACC_WRITE_BIT]) ||
                   (entry_hi[HI_RD_DIS_BIT] && pend_acc[ACC_READ_BIT]);
  end

  // phase sequencing and result select
  always_comb begin
    res       = '0;
    phase_nxt = phase;
    case (action)
      ACT_START: begin
        res.valid       = 1'b1;
        res.result_kind = KIND_FETCH_DIR;
        res.address     = dir_fetch_addr;
        res.status      = ST_OK;
        phase_nxt       = PH_DIR;
      end
      ACT_DIR_REPLY: begin
        if (phase == PH_DIR) begin
          res.valid = 1'b1;
          phase_nxt = PH_IDLE;
          if (bus_error) begin
            res.result_kind = KIND_DONE;
            res.status      = ST_BUS;
          end else if (big_ap || small_ap) begin
            res.result_kind = KIND_FETCH_TABLE;
            res.address     = tbl_fetch_addr;
            res.status      = ST_OK;
            phase_nxt       = PH_TABLE;
          end else begin
            res.result_kind = KIND_DONE;
            res.status      = ST_DECODE;
          end
        end
      end
      ACT_TABLE_REPLY: begin
        if (phase == PH_TABLE) begin
          res.valid       = 1'b1;
          res.result_kind = KIND_DONE;
          phase_nxt       = PH_IDLE;
          if (bus_error) begin
            res.status = ST_BUS;
          end else if (!entry_lo[LO_VALID_BIT]) begin
            res.status = ST_DECODE;
          end else if (access_fault) begin
            res.status = ST_ACCESS;
          end else begin
            res.address = phys_addr;
            res.status  = ST_OK;
          end
        end
      end
      default: begin
        res       = '0;
        phase_nxt = phase;
      end
    endcase
  end

endmodule

### src/gpu_two_level_page_walk.sv
// channel   | dir | payload                                                 | transfer
// in_chan   | in  | action, virt_addr, access_kind, entry_lo/hi, bus_error | valid & ready
// out_chan  | out | result_kind, address, status                            | valid & ready
// cfg_*     | in  | cfg_index, cfg_wdata                                    | cfg_we
//
// one item per cycle; an item is registered, evaluated in one combinational pass
// against the walk state, and its result is written to the output register
// synchronous active-low reset clears the walk state, the pipeline valids and the
// registers (dir_base to zero, 128 KiB big pages selected)
// a stalled output holds the input stage; an item with no result moves on regardless
module gpu_two_level_page_walk import pgw_pkg::*; #(
  parameter int VA_BITS = VA_BITS_DEF,
  parameter int PA_BITS = PA_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pgw_in_if.sink                in_chan,
  pgw_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIR_BASE_W-1:0] cfg_wdata
);

  cfg_t    cfg;
  result_t res;
  phase_t  phase_r, phase_nxt;

  logic               s1_v_r;
  logic [ACT_W-1:0]   s1_action_r;
  logic [VA_BITS-1:0] s1_va_r;
  logic [ACC_W-1:0]   s1_acc_r;
  logic [ENTRY_W-1:0] s1_lo_r;
  logic [ENTRY_W-1:0] s1_hi_r;
  logic               s1_berr_r;

  logic [VA_BITS-1:0] pend_va_r;
  logic [ACC_W-1:0]   pend_acc_r;

  logic                out_v_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [STATUS_W-1:0] out_status_r;

  logic out_free;
  logic s1_go;
  logic in_xfer;

  pgw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pgw_step #(
    .VA_W (VA_BITS),
    .PA_W (PA_BITS)
  ) u_step (
    .cfg       (cfg),
    .phase     (phase_r),
    .pend_va   (pend_va_r),
    .pend_acc  (pend_acc_r),
    .action    (s1_action_r),
    .item_va   (s1_va_r),
    .entry_lo  (s1_lo_r),
    .entry_hi  (s1_hi_r),
    .bus_error (s1_berr_r),
    .res       (res),
    .phase_nxt (phase_nxt)
  );

  // handshake
  assign out_free       = !out_v_r || out_chan.ready;
  assign s1_go          = s1_v_r && (!res.valid || out_free);
  assign in_chan.ready  = !s1_v_r || s1_go;
  assign in_xfer        = in_chan.valid && in_chan.ready;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      phase_r    <= PH_IDLE;
      pend_va_r  <= '0;
      pend_acc_r <= '0;
    end else begin
      if (in_xfer) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go && res.valid) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
      // walk state advances as each item leaves the input stage
      if (s1_go) begin
        phase_r <= phase_nxt;
        if (s1_action_r == ACT_START) begin
          pend_va_r  <= s1_va_r;
          pend_acc_r <= s1_acc_r;
        end
      end
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_action_r <= in_chan.action;
      s1_va_r     <= in_chan.virt_addr;
      s1_acc_r    <= in_chan.access_kind;
      s1_lo_r     <= in_chan.entry_lo;
      s1_hi_r     <= in_chan.entry_hi;
      s1_berr_r   <= in_chan.bus_error;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (s1_go && res.valid) begin
      out_kind_r   <= res.result_kind;
      out_addr_r   <= res.address;
      out_status_r <= res.status;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.address     = out_addr_r;
  assign out_chan.status      = out_status_r;

endmodule

### verif/gpu_two_level_page_walk_test.sv
module gpu_two_level_page_walk_test;
  import pgw_pkg::*;

  localparam int VA_W         = VA_BITS_DEF;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 228;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic             BY_MODEL   = 1'b0;
  localparam logic             TYPED      = 1'b1;
  localparam logic [63:0]      PA_MASK    = (64'd1 << PA_BITS_DEF) - 64'd1;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [VA_W-1:0]     virt_addr;
    logic [ACC_W-1:0]    access_kind;
    logic [ENTRY_W-1:0]  entry_lo;
    logic [ENTRY_W-1:0]  entry_hi;
    logic                bus_error;
    logic                typed;
    logic [KIND_W-1:0]   typed_kind;
    logic [ADDR_W-1:0]   typed_address;
    logic [STATUS_W-1:0] typed_status;
  } walk_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   address;
    logic [STATUS_W-1:0] status;
  } walk_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [DIR_BASE_W-1:0] cfg_wdata;

  pgw_in_if #(.VA_W(VA_W)) in_bus ();
  pgw_out_if out_bus ();

  gpu_two_level_page_walk #(
    .VA_BITS(VA_BITS_DEF),
    .PA_BITS(PA_BITS_DEF)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // shadow registers and walk state of the predictor
  logic [DIR_BASE_W-1:0] shadow_dir_base = '0;
  logic                  shadow_big_page = 1'b1;
  phase_t                walk_phase = PH_IDLE;
  logic [VA_W-1:0]       walk_va = '0;
  logic [ACC_W-1:0]      walk_access = '0;

  walk_result_t walk_results_due[$];
  walk_item_t   in_item;
  int           items_sent = 0;
  int           mismatches = 0;
  bit           in_calm = 1'b0;

  function automatic int page_shift_for(input logic [63:0] va);
    if ((va >> BIG_RANGE_BIT) != 0) begin
      return shadow_big_page ? PAGE_SHIFT_BIG_128K : PAGE_SHIFT_BIG_64K;
    end
    return PAGE_SHIFT_SMALL;
  endfunction

  // one step of the walk; returns 1 when the step produces a result
  function automatic bit predict_walk_step(input walk_item_t it, output walk_result_t res);
    logic [63:0] va;
    logic [63:0] base;
    logic [63:0] idx;
    logic [63:0] sum;
    logic [ENTRY_W-1:0] frame;
    int dshift;
    res = '0;
    res.status = ST_OK;
    dshift = shadow_big_page ? DIR_SHIFT_128K : DIR_SHIFT_64K;
    case (it.action)
      ACT_START: begin
        walk_va = it.virt_addr;
        walk_access = it.access_kind;
        walk_phase = PH_DIR;
        va = 64'(it.virt_addr);
        sum = 64'(shadow_dir_base) + ((va >> dshift) << ENTRY_SIZE_SHIFT);
        res.kind = KIND_FETCH_DIR;
        res.address = sum[ADDR_W-1:0];
        return 1'b1;
      end
      ACT_DIR_REPLY: begin
        if (walk_phase != PH_DIR) return 1'b0;
        walk_phase = PH_IDLE;
        res.kind = KIND_DONE;
        if (it.bus_error) begin
          res.status = ST_BUS;
          return 1'b1;
        end
        // big aperture takes priority over small
        if (it.entry_lo[LO_VALID_BIT] && it.entry_hi[HI_BIG_AP_BIT]) begin
          frame = it.entry_lo;
        end else if (it.entry_hi[HI_SMALL_AP_BIT] && it.entry_hi[HI_SMALL_VLD_BIT]) begin
          frame = it.entry_hi;
        end else begin
          res.status = ST_DECODE;
          return 1'b1;
        end
        base = ((64'(frame) >> ENTRY_FRAME_LSB) << FRAME_SHIFT) & PA_MASK;
        va = 64'(walk_va);
        idx = (va & ((64'd1 << dshift) - 64'd1)) >> page_shift_for(va);
        sum = base + (idx << ENTRY_SIZE_SHIFT);
        walk_phase = PH_TABLE;
        res.kind = KIND_FETCH_TABLE;
        res.address = sum[ADDR_W-1:0];
        return 1'b1;
      end
      ACT_TABLE_REPLY: begin
        if (walk_phase != PH_TABLE) return 1'b0;
        walk_phase = PH_IDLE;
        res.kind = KIND_DONE;
        if (it.bus_error) begin
          res.status = ST_BUS;
          return 1'b1;
        end
        if (!it.entry_lo[LO_VALID_BIT]) begin
          res.status = ST_DECODE;
          return 1'b1;
        end
        if ((it.entry_lo[LO_READ_ONLY_BIT] && walk_access[ACC_WRITE_BIT]) ||
            (it.entry_hi[HI_RD_DIS_BIT] && walk_access[ACC_READ_BIT])) begin
          res.status = ST_ACCESS;
          return 1'b1;
        end
        va = 64'(walk_va);
        sum = (((64'(it.entry_lo) >> ENTRY_FRAME_LSB) << FRAME_SHIFT) & PA_MASK) |
              (va & ((64'd1 << page_shift_for(va)) - 64'd1));
        res.address = sum[ADDR_W-1:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // check results and predict accepted items, both at the rising edge
  always @(posedge clk) begin : scoreboard
    walk_result_t got;
    walk_result_t due;
    walk_result_t res;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got.kind = out_bus.result_kind;
        got.address = out_bus.address;
        got.status = out_bus.status;
        if (walk_results_due.size() == 0) begin
          $error("result with nothing due: kind %0d address %h status %0d",
                 got.kind, got.address, got.status);
          mismatches++;
        end else begin
          due = walk_results_due.pop_front();
          if (got.kind !== due.kind) begin
            $error("result_kind mismatch: expected %0d, got %0d", due.kind, got.kind);
            mismatches++;
          end
          if (got.address !== due.address) begin
            $error("address mismatch: expected %h, got %h", due.address, got.address);
            mismatches++;
          end
          if (got.status !== due.status) begin
            $error("status mismatch: expected %0d, got %0d", due.status, got.status);
            mismatches++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        if (predict_walk_step(in_item, res)) begin
          if (in_item.typed) begin
            res.kind = in_item.typed_kind;
            res.address = in_item.typed_address;
            res.status = in_item.typed_status;
          end
          walk_results_due.push_back(res);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DIR_BASE: shadow_dir_base = cfg_wdata;
          REG_BIG_PAGE: shadow_big_page = cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  function automatic int pick_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // offer one item from the falling edge until its transfer
  task automatic send_item(input walk_item_t it);
    int gap;
    if (items_sent % 50 == 0) in_calm = ($urandom_range(0, 3) == 0);
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_item = it;
    in_bus.action = it.action;
    in_bus.virt_addr = it.virt_addr;
    in_bus.access_kind = it.access_kind;
    in_bus.entry_lo = it.entry_lo;
    in_bus.entry_hi = it.entry_hi;
    in_bus.bus_error = it.bus_error;
    in_bus.valid = 1'b1;
    items_sent++;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (walk_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIR_BASE_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic walk_item_t table_row(
    input logic [ACT_W-1:0] act, input logic [VA_W-1:0] va, input logic [ACC_W-1:0] acc,
    input logic [ENTRY_W-1:0] lo, input logic [ENTRY_W-1:0] hi, input logic berr,
    input logic typed, input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
    input logic [STATUS_W-1:0] status);
    walk_item_t it;
    it.action = act;
    it.virt_addr = va;
    it.access_kind = acc;
    it.entry_lo = lo;
    it.entry_hi = hi;
    it.bus_error = berr;
    it.typed = typed;
    it.typed_kind = kind;
    it.typed_address = addr;
    it.typed_status = status;
    return it;
  endfunction

  function automatic walk_item_t rand_payload(input logic [ACT_W-1:0] act);
    walk_item_t it;
    logic [63:0] wide;
    logic [31:0] r;
    wide = {$urandom, $urandom};
    r = $urandom;
    it = '0;
    it.action = act;
    it.virt_addr = wide[VA_W-1:0];
    it.access_kind = r[ACC_W-1:0];
    it.bus_error = r[ACC_W];
    it.entry_lo = $urandom;
    it.entry_hi = $urandom;
    return it;
  endfunction

  function automatic walk_item_t rand_start();
    walk_item_t it;
    it = rand_payload(ACT_START);
    // half the walks stay below the big-page range, some just above it
    if ($urandom_range(0, 1) == 0) begin
      it.virt_addr[VA_W-1:BIG_RANGE_BIT] = '0;
    end else if ($urandom_range(0, 5) == 0) begin
      it.virt_addr[VA_W-1:BIG_RANGE_BIT] = 4'd1;
    end
    return it;
  endfunction

  function automatic walk_item_t rand_dir_reply();
    walk_item_t it;
    int shape;
    it = rand_payload(ACT_DIR_REPLY);
    shape = $urandom_range(0, 9);
    if (shape < 4) begin
      it.entry_lo[LO_VALID_BIT] = 1'b1;
      it.entry_hi[HI_BIG_AP_BIT] = 1'b1;
    end else if (shape < 8) begin
      it.entry_hi[HI_SMALL_AP_BIT] = 1'b1;
      it.entry_hi[HI_SMALL_VLD_BIT] = 1'b1;
    end
    it.bus_error = ($urandom_range(0, 15) == 0);
    return it;
  endfunction

  function automatic walk_item_t rand_table_reply();
    walk_item_t it;
    it = rand_payload(ACT_TABLE_REPLY);
    it.entry_lo[LO_VALID_BIT] = ($urandom_range(0, 9) != 0);
    it.entry_lo[LO_READ_ONLY_BIT] = ($urandom_range(0, 3) == 0);
    it.entry_hi[HI_RD_DIS_BIT] = ($urandom_range(0, 3) == 0);
    it.bus_error = ($urandom_range(0, 15) == 0);
    return it;
  endfunction

  // mostly complete walks, some abandoned or with stray replies
  task automatic send_random_walk();
    int shape;
    shape = $urandom_range(0, 9);
    send_item(rand_start());
    if (shape == 0) return;
    if (shape == 1) send_item(rand_table_reply());
    send_item(rand_dir_reply());
    if (shape == 2) send_item(rand_dir_reply());
    send_item(rand_table_reply());
  endtask

  // result side: random stalls, two long hold-offs
  initial begin : result_sink
    int wait_cycles;
    int xfers;
    bit calm;
    out_bus.ready = 1'b0;
    xfers = 0;
    calm = 1'b0;
    forever begin
      if (xfers % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      wait_cycles = pick_gap(calm);
      if (xfers == 150 || xfers == 900) wait_cycles = HOLD_CYCLES;
      if (wait_cycles > 0) begin
        @(negedge clk);
        out_bus.ready = 1'b0;
        repeat (wait_cycles - 1) @(negedge clk);
      end
      @(negedge clk);
      out_bus.ready = 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      xfers++;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    walk_item_t rows[$];
    logic [63:0] wide;
    int random_start;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_DIR_BASE;
    cfg_wdata = '0;
    in_item = '0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_START;
    in_bus.virt_addr = '0;
    in_bus.access_kind = '0;
    in_bus.entry_lo = '0;
    in_bus.entry_hi = '0;
    in_bus.bus_error = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed walks under reset settings: dir_base zero, 128 KiB big pages
    rows.push_back(table_row(ACT_START, 38'h0, 2'd1, 32'h0, 32'h0, 1'b0,
                             TYPED, KIND_FETCH_DIR, 35'h0, ST_OK));
    // start while busy drops the first walk
    rows.push_back(table_row(ACT_START, 38'h3F_FFFF_FFFF, 2'd3, 32'h0, 32'h0, 1'b0,
                             TYPED, KIND_FETCH_DIR, 35'h3FF8, ST_OK));
    rows.push_back(table_row(ACT_DIR_REPLY, 38'h0, 2'd0, 32'h0, 32'h0, 1'b1,
                             TYPED, KIND_DONE, 35'h0, ST_BUS));
    // replies while idle and the unused action code are ignored
    rows.push_back(table_row(ACT_DIR_REPLY, 38'h0, 2'd0, 32'hFFFF_FFF1, 32'h8, 1'b0,
                             BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    rows.push_back(table_row(ACT_TABLE_REPLY, 38'h0, 2'd0, 32'h1, 32'h0, 1'b0,
                             BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    rows.push_back(table_row(ACT_UNUSED, 38'h3F_FFFF_FFFF, 2'd3, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 1'b1, BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    // first address of the big-page range
    rows.push_back(table_row(ACT_START, 38'h4_0000_0000, 2'd2, 32'h0, 32'h0, 1'b0,
                             TYPED, KIND_FETCH_DIR, 35'h400, ST_OK));
    // table reply while the directory entry is awaited
    rows.push_back(table_row(ACT_TABLE_REPLY, 38'h0, 2'd0, 32'h1, 32'h0, 1'b0,
                             BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    // both apertures set: the big one wins
    rows.push_back(table_row(ACT_DIR_REPLY, 38'h0, 2'd0, 32'hFFFF_FFF1, 32'hD, 1'b0,
                             TYPED, KIND_FETCH_TABLE, 35'h3_FFFF_F000, ST_OK));
    // read-only page on a write
    rows.push_back(table_row(ACT_TABLE_REPLY, 38'h0, 2'd0, 32'h5, 32'h0, 1'b0,
                             TYPED, KIND_DONE, 35'h0, ST_ACCESS));
    rows.push_back(table_row(ACT_START, 38'h3F_FFFF_FFFF, 2'd1, 32'h0, 32'h0, 1'b0,
                             BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    rows.push_back(table_row(ACT_DIR_REPLY, 38'h0, 2'd0, 32'h0, 32'h5, 1'b0,
                             BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    // read-disabled page on a read
    rows.push_back(table_row(ACT_TABLE_REPLY, 38'h0, 2'd0, 32'h1, 32'h4000_0000, 1'b0,
                             TYPED, KIND_DONE, 35'h0, ST_ACCESS));
    rows.push_back(table_row(ACT_START, 38'h0_1234_5678, 2'd0, 32'h0, 32'h0, 1'b0,
                             BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    // directory entry with no aperture
    rows.push_back(table_row(ACT_DIR_REPLY, 38'h0, 2'd0, 32'h0, 32'h0, 1'b0,
                             TYPED, KIND_DONE, 35'h0, ST_DECODE));
    rows.push_back(table_row(ACT_START, 38'h1_2345_6789, 2'd3, 32'h0, 32'h0, 1'b0,
                             BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    rows.push_back(table_row(ACT_DIR_REPLY, 38'h0, 2'd0, 32'h0000_1231, 32'h8, 1'b0,
                             BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    rows.push_back(table_row(ACT_TABLE_REPLY, 38'h0, 2'd0, 32'h1, 32'h0, 1'b1,
                             TYPED, KIND_DONE, 35'h0, ST_BUS));
    rows.push_back(table_row(ACT_START, 38'h0_0ABC_DEF0, 2'd0, 32'h0, 32'h0, 1'b0,
                             BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    rows.push_back(table_row(ACT_DIR_REPLY, 38'h0, 2'd0, 32'h0, 32'hFFFF_FFF5, 1'b0,
                             BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    // invalid table entry
    rows.push_back(table_row(ACT_TABLE_REPLY, 38'h0, 2'd0, 32'h0, 32'h0, 1'b0,
                             TYPED, KIND_DONE, 35'h0, ST_DECODE));
    rows.push_back(table_row(ACT_START, 38'h2A_5A5A_5A5A, 2'd3, 32'h0, 32'h0, 1'b0,
                             BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    rows.push_back(table_row(ACT_DIR_REPLY, 38'h0, 2'd0, 32'hA5A5_A5A1, 32'h8, 1'b0,
                             BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    rows.push_back(table_row(ACT_TABLE_REPLY, 38'h0, 2'd0, 32'hFFFF_FFF1, 32'hBFFF_FFFF,
                             1'b0, BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    rows.push_back(table_row(ACT_TABLE_REPLY, 38'h0, 2'd0, 32'h1, 32'h0, 1'b0,
                             BY_MODEL, KIND_FETCH_DIR, 35'h0, ST_OK));
    foreach (rows[i]) send_item(rows[i]);
    release_input();
    wait_drained();

    // random walks under a sequence of register settings
    random_start = items_sent;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 2: wide = PA_MASK;
        1, 3: wide = '0;
        default: wide = {$urandom, $urandom};
      endcase
      write_reg(REG_DIR_BASE, wide[DIR_BASE_W-1:0]);
      // only bit 0 of the big-page register counts, upper bits are noise
      wide = {$urandom, $urandom};
      if (p < 4) wide[0] = p[0];
      write_reg(REG_BIG_PAGE, wide[DIR_BASE_W-1:0]);
      while (items_sent < random_start + (p + 1) * PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          wide = {$urandom, $urandom};
          send_item(rand_payload(wide[ACT_W-1:0]));
        end else begin
          send_random_walk();
        end
      end
      release_input();
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
